// ===== rtl/wla_pkg.sv =====
// Shared types and constants of the windowed latency average unit.
`default_nettype none

package wla_pkg;

	localparam int LAT_W   = 32;
	localparam int STAMP_W = 48;
	localparam int CNT_O_W = 6;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 1'd1;

	localparam logic [LAT_W-1:0] WINDOW_RESET = 32'd60000;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WALK  = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_DENOM = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	typedef struct packed {
		logic accept;
		logic walk_rd;
		logic load_denom;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
		logic pipe_busy;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/wla_req_if.sv =====
// Request channel: latency and timestamp of one request.
`default_nettype none

interface wla_req_if;
	import wla_pkg::*;

	logic               valid;
	logic               ready;
	logic [LAT_W-1:0]   latency_ms;
	logic [STAMP_W-1:0] now_ms;

	modport source (output valid, output latency_ms, output now_ms, input ready);
	modport sink   (input valid, input latency_ms, input now_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/wla_res_if.sv =====
// Result channel: windowed average and number of samples counted.
`default_nettype none

interface wla_res_if;
	import wla_pkg::*;

	logic               valid;
	logic               ready;
	logic [LAT_W-1:0]   average_ms;
	logic [CNT_O_W-1:0] samples_counted;

	modport source (output valid, output average_ms, output samples_counted, input ready);
	modport sink   (input valid, input average_ms, input samples_counted, output ready);
endinterface

`default_nettype wire

// ===== rtl/wla_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module wla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

`default_nettype wire

// ===== rtl/wla_ctrl.sv =====
// Sequencer of the windowed latency average unit.
`default_nettype none

module wla_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output      logic         in_ready,
	input  wire wla_pkg::sts_t sts,
	output      wla_pkg::cmd_t cmd
);
	import wla_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk_rd = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_DENOM;
				end
			end
			ST_DENOM: begin
				cmd.load_denom = 1'b1;
				state_d        = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

`default_nettype wire

// ===== rtl/wla_dp.sv =====
// Datapath: sample ring, window walk, accumulation, divider and result register.
`default_nettype none

module wla_dp #(
	parameter int QUEUE_LEN = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         mode,
	input  wire logic [wla_pkg::LAT_W-1:0]    window,
	input  wire logic [wla_pkg::LAT_W-1:0]    lat_in,
	input  wire logic [wla_pkg::STAMP_W-1:0]  now_in,
	input  wire wla_pkg::cmd_t                cmd,
	output      wla_pkg::sts_t                sts,
	input  wire logic                         out_ready,
	output      logic                         out_valid,
	output      logic [wla_pkg::LAT_W-1:0]    avg_out,
	output      logic [wla_pkg::CNT_O_W-1:0]  cnt_out
);
	import wla_pkg::*;

	localparam int AW     = $clog2(QUEUE_LEN);
	localparam int CNT_W  = $clog2(QUEUE_LEN);
	localparam int SUM_W  = LAT_W + $clog2(QUEUE_LEN * (QUEUE_LEN - 1) / 2 + 1);
	localparam int DEN_W  = 2 * CNT_W;
	localparam int PROD_W = LAT_W + CNT_W + 1;
	localparam int SLOT_W = STAMP_W + LAT_W;
	localparam int DIV_CW = $clog2(SUM_W);

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		return (p == AW'(QUEUE_LEN - 1)) ? '0 : p + AW'(1);
	endfunction

	logic [AW-1:0]      oldest_q, free_q, rd_addr_q;
	logic [CNT_W-1:0]   fill_q, fill_nxt, walk_n_q, skip_q, count_q;
	logic [STAMP_W-1:0] cutoff_q, cutoff_d;
	logic [SLOT_W-1:0]  rd_data;
	logic               rd_vld_s1, written_s1, pipe_s2, hit_s2, hit;
	logic [PROD_W-1:0]  prod_s2, prod_d;
	logic [CNT_W:0]     rank;
	logic [SUM_W-1:0]   sum_q, quo_q;
	logic [DEN_W-1:0]   denom_q, rem_q, denom_d;
	logic [DEN_W:0]     rem_sh;
	logic               rem_ge;
	logic [DIV_CW-1:0]  div_n_q;
	logic [LAT_W-1:0]   avg_q;
	logic [CNT_O_W-1:0] cnt_q;
	logic               out_valid_q;

	wla_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_LEN)) u_ring (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (free_q),
		.wdata ({now_in, lat_in}),
		.re    (cmd.walk_rd),
		.raddr (rd_addr_q),
		.rdata (rd_data)
	);

	assign fill_nxt = (fill_q == CNT_W'(QUEUE_LEN - 1)) ? fill_q : fill_q + CNT_W'(1);

	always_comb begin
		if (window == '0 || now_in < STAMP_W'(window)) begin
			cutoff_d = '0;
		end else begin
			cutoff_d = now_in - STAMP_W'(window);
		end
	end

	// Slots never written since reset are left out through the fill count; a stamp of zero is never counted.
	assign hit    = rd_vld_s1 && written_s1 && (cutoff_q < rd_data[SLOT_W-1:LAT_W]);
	assign rank   = (CNT_W + 1)'(count_q) + (CNT_W + 1)'(1);
	assign prod_d = mode ? PROD_W'(rd_data[LAT_W-1:0]) * PROD_W'(rank)
	                     : PROD_W'(rd_data[LAT_W-1:0]);

	assign denom_d = mode ? DEN_W'((DEN_W'(count_q) * DEN_W'(rank)) >> 1) : DEN_W'(count_q);
	assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
	assign rem_ge  = rem_sh >= (DEN_W + 1)'(denom_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q    <= '0;
			free_q      <= AW'(QUEUE_LEN - 1);
			fill_q      <= '0;
			rd_vld_s1   <= 1'b0;
			pipe_s2     <= 1'b0;
			hit_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.walk_rd;
			pipe_s2   <= rd_vld_s1;
			hit_s2    <= hit;
			if (cmd.accept) begin
				oldest_q <= ring_inc(oldest_q);
				free_q   <= ring_inc(free_q);
				fill_q   <= fill_nxt;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		written_s1 <= walk_n_q >= skip_q;
		prod_s2    <= prod_d;
		if (cmd.accept) begin
			cutoff_q  <= cutoff_d;
			rd_addr_q <= ring_inc(oldest_q);
			walk_n_q  <= '0;
			skip_q    <= CNT_W'(QUEUE_LEN - 1) - fill_nxt;
			count_q   <= '0;
			sum_q     <= '0;
		end else begin
			if (cmd.walk_rd) begin
				rd_addr_q <= ring_inc(rd_addr_q);
				walk_n_q  <= walk_n_q + CNT_W'(1);
			end
			if (hit) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (hit_s2) begin
				sum_q <= sum_q + SUM_W'(prod_s2);
			end
		end
		if (cmd.load_denom) begin
			denom_q <= denom_d;
			quo_q   <= sum_q;
			rem_q   <= '0;
			div_n_q <= '0;
		end else if (cmd.div_step) begin
			rem_q   <= rem_ge ? DEN_W'(rem_sh - (DEN_W + 1)'(denom_q)) : DEN_W'(rem_sh);
			quo_q   <= {quo_q[SUM_W-2:0], rem_ge};
			div_n_q <= div_n_q + DIV_CW'(1);
		end
		if (cmd.load_out) begin
			avg_q <= (count_q == '0) ? '0 : LAT_W'(quo_q);
			cnt_q <= CNT_O_W'(count_q);
		end
	end

	assign sts.walk_last = walk_n_q == CNT_W'(QUEUE_LEN - 2);
	assign sts.pipe_busy = rd_vld_s1 || pipe_s2;
	assign sts.div_last  = div_n_q == DIV_CW'(SUM_W - 1);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign avg_out   = avg_q;
	assign cnt_out   = cnt_q;
endmodule

`default_nettype wire

// ===== rtl/windowed_latency_average_unit.sv =====
// Top level of the windowed latency average unit.
//
// Each request transfer carries a latency and the current millisecond time. The pair
// replaces the oldest of QUEUE_LEN-1 samples held in a ring, after which every live
// sample is visited from oldest to newest and those stamped later than the cutoff
// (now minus window_ms, held at zero when the window is zero or longer than now) are
// counted. The result transfer carries either their truncated plain mean or their mean
// weighted 1 to c from oldest to newest, and the count; both are zero when nothing
// falls inside the window. The ring walk reads one slot per cycle through the single
// read port of the sample memory, a drain state waits until the read and accumulate
// pipeline is empty, a denominator state forms the divisor, the divider retires one
// quotient bit per cycle and a final state loads the output register once it is free.
// The next request is taken in the cycle after that at the earliest, so requests are
// worked one at a time. A finished result waits in its own output register, so the
// next request is taken while it is still unclaimed; a new result is held back only
// while the previous one has not been transferred. Slots not yet written since reset
// are tracked by a fill count, so no clearing pass is needed and the unit is ready
// straight out of reset.
`default_nettype none

module windowed_latency_average_unit #(
	parameter int QUEUE_LEN = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	wla_req_if.sink                              req,
	wla_res_if.source                            res,
	input  wire logic                            cfg_we,
	input  wire logic [wla_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [wla_pkg::CFG_W-1:0]       cfg_wdata
);
	import wla_pkg::*;

	// Configuration registers: user writes only with no request in flight; not enforced.
	logic             mode_q;
	logic [LAT_W-1:0] window_q;
	cmd_t             cmd;
	sts_t             sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			priority if (cfg_idx == REG_AVERAGE_MODE) begin
				mode_q <= cfg_wdata[0];
			end else if (cfg_idx == REG_WINDOW_MS) begin
				window_q <= cfg_wdata[LAT_W-1:0];
			end
		end
	end

	// The controller only sequences; all sample storage and arithmetic sit in the datapath.
	wla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wla_dp #(.QUEUE_LEN(QUEUE_LEN)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.window    (window_q),
		.lat_in    (req.latency_ms),
		.now_in    (req.now_ms),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (res.ready),
		.out_valid (res.valid),
		.avg_out   (res.average_ms),
		.cnt_out   (res.samples_counted)
	);
endmodule

`default_nettype wire

// ===== rtl/wla_checker.sv =====
// Port-level checks of the windowed latency average unit and their binding.
`default_nettype none

module wla_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           req_valid,
	input wire logic                           req_ready,
	input wire logic                           res_valid,
	input wire logic                           res_ready,
	input wire logic [wla_pkg::LAT_W-1:0]      average_ms,
	input wire logic [wla_pkg::CNT_O_W-1:0]    samples_counted
);
	import wla_pkg::*;

	// An empty window must report a zero average.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && samples_counted == '0 |-> average_ms == '0)
		else $error("nonzero average with no samples counted");

	// Requests are worked one at a time: no second transfer straight after one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one is in progress");

	// The ring walk and the division lie between a request and its result, so no result follows at once.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(res_valid))
		else $error("result appeared one cycle after a request");

	// A stalled result holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(average_ms)
			&& $stable(samples_counted))
		else $error("stalled result changed or vanished");
endmodule

bind windowed_latency_average_unit wla_checker u_wla_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.average_ms      (res.average_ms),
	.samples_counted (res.samples_counted)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the windowed latency average unit.
`timescale 1ns / 1ps

module tb;
	import wla_pkg::*;

	localparam int QUEUE_LEN       = 64;
	localparam int LIVE_SAMPLES    = QUEUE_LEN - 1;
	localparam int RANDOM_REQUESTS = 1500;
	// The tail after the last result runs a little longer than one request keeps
	// the unit busy.
	localparam int TAIL_CYCLES     = 130;
	localparam int REPORT_LIMIT    = 10;

	typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [LAT_W-1:0]   latency;
	} sample_t;

	typedef struct packed {
		logic [LAT_W-1:0]   average_ms;
		logic [CNT_O_W-1:0] samples_counted;
	} window_avg_t;

	// One line of the directed table: either a register write or a request, the latter
	// optionally with its result written out by hand.
	typedef struct packed {
		row_kind_t          kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]   wdata;
		logic [LAT_W-1:0]   latency;
		logic [STAMP_W-1:0] now;
		logic               typed;
		window_avg_t        result;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	wla_req_if request_ch ();
	wla_res_if result_ch ();

	windowed_latency_average_unit #(
		.QUEUE_LEN(QUEUE_LEN)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (request_ch),
		.res       (result_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Our own copy of the unit's state: the live samples, oldest at the front, and the
	// two registers as last written.
	sample_t          live_samples[$];
	logic             weighted_mode;
	logic [LAT_W-1:0] window_limit;

	window_avg_t pending_averages[$];
	int unsigned mismatches;
	stim_row_t   directed_rows[$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Drops the oldest sample, appends the new one and works out the windowed mean
	// exactly as the unit should: samples are counted when their stamp is strictly
	// later than the cutoff, and the weights run 1..c from oldest to newest.
	function automatic window_avg_t predict_average(input logic [LAT_W-1:0] latency,
			input logic [STAMP_W-1:0] now);
		logic [STAMP_W-1:0] cutoff;
		logic [63:0]        total;
		logic [63:0]        counted;
		logic [63:0]        divisor;
		logic [63:0]        quotient;
		sample_t            fresh;
		window_avg_t        outcome;
		fresh.stamp   = now;
		fresh.latency = latency;
		live_samples.delete(0);
		live_samples.push_back(fresh);
		// A zero window places no age limit, and a window longer than the present time
		// holds the cutoff at zero rather than letting it wrap.
		if (window_limit == '0 || now < STAMP_W'(window_limit))
			cutoff = '0;
		else
			cutoff = now - STAMP_W'(window_limit);
		total   = '0;
		counted = '0;
		foreach (live_samples[k]) begin
			if (live_samples[k].stamp > cutoff) begin
				counted = counted + 64'd1;
				if (weighted_mode)
					total = total + 64'(live_samples[k].latency) * counted;
				else
					total = total + 64'(live_samples[k].latency);
			end
		end
		quotient = '0;
		if (counted != '0) begin
			divisor  = weighted_mode ? (counted * (counted + 64'd1)) / 64'd2 : counted;
			quotient = total / divisor;
		end
		outcome.average_ms      = quotient[LAT_W-1:0];
		outcome.samples_counted = counted[CNT_O_W-1:0];
		return outcome;
	endfunction

	function automatic stim_row_t request_row(input logic [LAT_W-1:0] latency,
			input logic [STAMP_W-1:0] now);
		stim_row_t row;
		row         = '0;
		row.kind    = ROW_REQUEST;
		row.latency = latency;
		row.now     = now;
		return row;
	endfunction

	function automatic stim_row_t typed_row(input logic [LAT_W-1:0] latency,
			input logic [STAMP_W-1:0] now, input logic [LAT_W-1:0] average,
			input logic [CNT_O_W-1:0] counted);
		stim_row_t row;
		row                        = request_row(latency, now);
		row.typed                  = 1'b1;
		row.result.average_ms      = average;
		row.result.samples_counted = counted;
		return row;
	endfunction

	function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		stim_row_t row;
		row         = '0;
		row.kind    = ROW_WRITE;
		row.reg_idx = idx;
		row.wdata   = data;
		return row;
	endfunction

	// Offers one request after the given number of idle cycles and records what the
	// unit owes for it once the transfer has happened. While idle, the latency field carries
	// junk so that the unit is seen to ignore it.
	task automatic send_request(input logic [LAT_W-1:0] latency,
			input logic [STAMP_W-1:0] now, input int unsigned gap, input logic typed,
			input window_avg_t typed_result);
		window_avg_t predicted;
		if (gap != 0) begin
			request_ch.valid      <= 1'b0;
			request_ch.latency_ms <= $urandom();
			repeat (gap) @(posedge clk);
		end
		request_ch.valid      <= 1'b1;
		request_ch.latency_ms <= latency;
		request_ch.now_ms     <= now;
		do @(posedge clk); while (!request_ch.ready);
		predicted = predict_average(latency, now);
		pending_averages.push_back(typed ? typed_result : predicted);
	endtask

	// Stops offering requests and waits for every outstanding result. Always waits on the
	// clock before testing, so valid is never lowered and raised in the same step.
	task automatic drain_results();
		request_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_averages.size() != 0);
	endtask

	// Writes one register. The write enable stays high when another write follows at
	// once, so that it is not dropped and raised again within one step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
			input logic more);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		if (!more)
			cfg_we <= 1'b0;
		case (idx)
			REG_AVERAGE_MODE: weighted_mode = data[0];
			REG_WINDOW_MS:    window_limit  = data;
			default: ;
		endcase
	endtask

	// Result side: stalls for a random number of cycles before each transfer, with
	// calm stretches where it takes every result at once.
	initial begin : result_sink
		int unsigned stall;
		int unsigned calm_left;
		window_avg_t wanted;
		calm_left = 0;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (calm_left == 0 && $urandom_range(0, 19) == 0)
				calm_left = $urandom_range(10, 60);
			if (calm_left != 0) begin
				stall     = 0;
				calm_left = calm_left - 1;
			end else begin
				stall = $urandom_range(0, 9);
			end
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			if (pending_averages.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: average_ms %0d samples_counted %0d",
						result_ch.average_ms, result_ch.samples_counted);
			end else begin
				wanted = pending_averages.pop_front();
				if (result_ch.average_ms !== wanted.average_ms ||
						result_ch.samples_counted !== wanted.samples_counted) begin
					mismatches = mismatches + 1;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: average_ms exp %0d got %0d, samples_counted exp %0d got %0d",
							wanted.average_ms, result_ch.average_ms,
							wanted.samples_counted, result_ch.samples_counted);
				end
			end
		end
	end

	initial begin : run_limit
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned        sent;
		int unsigned        phase_len;
		int unsigned        step_max;
		int unsigned        pause_at;
		logic [LAT_W-1:0]   latency;
		logic [LAT_W-1:0]   window;
		logic [STAMP_W-1:0] stamp_clock;
		logic [STAMP_W-1:0] now;
		logic [63:0]        wide;
		logic               quiet;
		logic               more;

		// Every input of the unit is known from the very start.
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_idx               = REG_AVERAGE_MODE;
		cfg_wdata             = '0;
		request_ch.valid      = 1'b0;
		request_ch.latency_ms = '0;
		request_ch.now_ms     = '0;
		mismatches            = 0;

		// The model starts from QUEUE_LEN-1 samples of latency zero stamped zero, which never count.
		weighted_mode = 1'b0;
		window_limit  = WINDOW_RESET;
		for (int k = 0; k < LIVE_SAMPLES; k++)
			live_samples.push_back('0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The first rows follow straight from the reset state: a sample
		// stamped zero never counts, a lone sample gives its own latency, the cutoff just
		// below the largest time excludes everything older, and a stamp far in the future
		// still counts once the present time moves back below it.
		directed_rows.push_back(typed_row(32'd123, 48'd0, 32'd0, 6'd0));
		directed_rows.push_back(typed_row(32'hFFFF_FFFF, 48'd5, 32'hFFFF_FFFF, 6'd1));
		directed_rows.push_back(typed_row(32'd7, 48'hFFFF_FFFF_FFFF, 32'd7, 6'd1));
		directed_rows.push_back(typed_row(32'd100, 48'd10, 32'd1431655800, 6'd3));
		// Weighted mean, written with every stray bit of the data word set.
		directed_rows.push_back(write_row(REG_AVERAGE_MODE, 32'hFFFF_FFFF));
		directed_rows.push_back(request_row(32'hFFFF_FFFF, 48'd20));
		directed_rows.push_back(request_row(32'd1, 48'd30));
		// No age limit at all.
		directed_rows.push_back(write_row(REG_WINDOW_MS, 32'd0));
		directed_rows.push_back(request_row(32'd0, 48'd0));
		directed_rows.push_back(request_row(32'd5, 48'd40));
		// Largest window: the cutoff is one just past it and zero when the time equals it.
		directed_rows.push_back(write_row(REG_WINDOW_MS, 32'hFFFF_FFFF));
		directed_rows.push_back(request_row(32'd9, 48'h0001_0000_0000));
		directed_rows.push_back(request_row(32'd2, 48'h0000_FFFF_FFFF));
		// Back to the plain mean with stray bits set, and the narrowest window.
		directed_rows.push_back(write_row(REG_AVERAGE_MODE, 32'hFFFF_FFFE));
		directed_rows.push_back(write_row(REG_WINDOW_MS, 32'd1));
		directed_rows.push_back(request_row(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
		directed_rows.push_back(request_row(32'd0, 48'h8000_0000_0000));
		directed_rows.push_back(write_row(REG_WINDOW_MS, WINDOW_RESET));
		directed_rows.push_back(request_row(32'h8000_0000, 48'd60001));

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_WRITE) begin
				// Registers change only with the unit idle, so a run of writes starts
				// by collecting every outstanding result.
				if (r == 0 || directed_rows[r-1].kind != ROW_WRITE)
					drain_results();
				more = (r + 1 < directed_rows.size()) &&
					(directed_rows[r+1].kind == ROW_WRITE);
				write_reg(directed_rows[r].reg_idx, directed_rows[r].wdata, more);
			end else begin
				send_request(directed_rows[r].latency, directed_rows[r].now,
					$urandom_range(0, 9), directed_rows[r].typed, directed_rows[r].result);
			end
		end

		// Random part, in phases. Each phase picks a mode, a window and a typical step
		// between timestamps, so that the number of samples inside the window ranges
		// from none to the whole ring. Most stamps march forward; some arrive late, some
		// lie far in the future and some are wholly random.
		sent        = 0;
		pause_at    = $urandom_range(100, 1000);
		wide        = {$urandom(), $urandom()};
		stamp_clock = {8'd0, wide[39:0]};
		while (sent < RANDOM_REQUESTS) begin
			drain_results();
			step_max = $urandom_range(1, 2000);
			case ($urandom_range(0, 6))
				0:       window = '0;
				1:       window = 32'hFFFF_FFFF;
				2:       window = 32'd1;
				3:       window = WINDOW_RESET;
				default: window = $urandom_range(1, step_max * 70);
			endcase
			write_reg(REG_AVERAGE_MODE, $urandom(), 1'b1);
			write_reg(REG_WINDOW_MS, window, 1'b0);

			// Now and then the time restarts near zero, where the cutoff saturates, or
			// jumps to anywhere in the full 48-bit range.
			case ($urandom_range(0, 9))
				0: stamp_clock = STAMP_W'($urandom_range(0, 1000));
				1: begin
					wide        = {$urandom(), $urandom()};
					stamp_clock = wide[STAMP_W-1:0];
				end
				default: ;
			endcase

			phase_len = $urandom_range(40, 200);
			quiet     = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < phase_len && sent < RANDOM_REQUESTS; n++) begin
				case ($urandom_range(0, 7))
					0:       latency = '0;
					1:       latency = 32'hFFFF_FFFF;
					2, 3:    latency = $urandom_range(0, 1000);
					default: latency = $urandom();
				endcase
				case ($urandom_range(0, 19))
					0: now = stamp_clock - STAMP_W'($urandom_range(0, step_max * 3));
					1: now = stamp_clock + STAMP_W'($urandom_range(1, step_max * 200));
					2: begin
						wide = {$urandom(), $urandom()};
						now  = wide[STAMP_W-1:0];
					end
					default: begin
						stamp_clock = stamp_clock + STAMP_W'($urandom_range(0, step_max));
						now         = stamp_clock;
					end
				endcase
				// Sometimes the sender holds back until the unit has handed over
				// everything it owes.
				if (sent == pause_at || $urandom_range(0, 63) == 0)
					drain_results();
				send_request(latency, now, quiet ? 0 : $urandom_range(0, 9), 1'b0, '0);
				sent = sent + 1;
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_averages.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
